[rtl/iiq_pkg.sv]
package iiq_pkg;

    localparam int IDX_W      = 10;
    localparam int NUM_POINTS = 1 << IDX_W;
    localparam int COORD_W    = 16;
    localparam int ID_W       = 16;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int LIFT_W     = SQ_W + 1;
    localparam int MLO_W      = 18;
    localparam int MHI_W      = LIFT_W - MLO_W;
    localparam int PLO_W      = LIFT_W + MLO_W + 1;
    localparam int PHI_W      = LIFT_W + MHI_W;
    localparam int SUM_W      = 72;
    localparam int RES_W      = ID_W + 1;
    localparam int LATENCY    = 7;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [RES_W-1:0] NO_MATCH = '1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic        [ID_W-1:0]    id;
    } t_point;

endpackage

[rtl/indexed_incircle_query.sv]
// Indexed in-circle query.
// Holds a table of 1024 points (x, y, id). A transaction is accepted on a
// rising edge where start is high and busy is low; busy is always low, so one
// transaction can be accepted every cycle.
// A load transaction (i_req_type = 0) writes entry i_load_index and gives no
// result. A query transaction (i_req_type = 1) reads entries i_query_d, _a,
// _b and _c and evaluates the exact in-circle determinant of a, b, c relative
// to d. The result o_match_id is d's id if the determinant is strictly
// positive, else -1, shown for one cycle with strobe high.
// Pipeline: seven register stages (table read, differences, squares and
// cross products, lifts and minors, split 35x18/35x17 products, product
// assembly, final sum and sign); the last one drives strobe and o_match_id.
// Throughput: one transaction per cycle; the table is two copies, each read
// at two addresses per cycle.
// A load followed by a query in the next cycle sees the new entry.
// Reset clears the pipeline valid bits only; table entries stay undefined
// until loaded and must not be queried before. The receiver cannot stall:
// each result is taken in the cycle it is shown.
module indexed_incircle_query import iiq_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_req_type,
    input  logic        [IDX_W-1:0]   i_load_index,
    input  logic signed [COORD_W-1:0] i_point_x,
    input  logic signed [COORD_W-1:0] i_point_y,
    input  logic        [ID_W-1:0]    i_point_id,
    input  logic        [IDX_W-1:0]   i_query_d,
    input  logic        [IDX_W-1:0]   i_query_a,
    input  logic        [IDX_W-1:0]   i_query_b,
    input  logic        [IDX_W-1:0]   i_query_c,
    output logic                      strobe,
    output logic signed [RES_W-1:0]   o_match_id
);

    t_point mem_lo [NUM_POINTS];
    t_point mem_hi [NUM_POINTS];

    logic w_load;
    logic w_query;

    logic [LATENCY-1:0] r_vld;

    t_point r_pd;
    t_point r_pk [3];

    logic signed [DIFF_W-1:0] r_dx [3];
    logic signed [DIFF_W-1:0] r_dy [3];
    logic signed [DIFF_W-1:0] n_dx [3];
    logic signed [DIFF_W-1:0] n_dy [3];

    logic signed [SQ_W-1:0] r_sqx [3];
    logic signed [SQ_W-1:0] r_sqy [3];
    logic signed [SQ_W-1:0] r_mp  [3];
    logic signed [SQ_W-1:0] r_mn  [3];

    logic signed [LIFT_W-1:0] r_lift  [3];
    logic signed [LIFT_W-1:0] r_minor [3];
    logic signed [LIFT_W-1:0] n_lift  [3];
    logic signed [LIFT_W-1:0] n_minor [3];

    logic signed [MLO_W:0]   w_mlo [3];
    logic signed [MHI_W-1:0] w_mhi [3];
    logic signed [PLO_W-1:0] r_plo [3];
    logic signed [PHI_W-1:0] r_phi [3];

    logic signed [SUM_W-1:0] r_prod [3];
    logic signed [SUM_W-1:0] n_prod [3];
    logic signed [SUM_W-1:0] n_det;
    logic                    n_pos;

    logic [ID_W-1:0] r_id2;
    logic [ID_W-1:0] r_id3;
    logic [ID_W-1:0] r_id4;
    logic [ID_W-1:0] r_id5;
    logic [ID_W-1:0] r_id6;

    logic signed [RES_W-1:0] r_match;

    assign busy    = 1'b0;
    assign w_load  = start && !busy && (i_req_type == REQ_LOAD);
    assign w_query = start && !busy && (i_req_type == REQ_QUERY);

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            mem_lo[i_load_index] <= '{x: i_point_x, y: i_point_y, id: i_point_id};
            mem_hi[i_load_index] <= '{x: i_point_x, y: i_point_y, id: i_point_id};
        end
        r_pd    <= mem_lo[i_query_d];
        r_pk[0] <= mem_lo[i_query_a];
        r_pk[1] <= mem_hi[i_query_b];
        r_pk[2] <= mem_hi[i_query_c];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LATENCY-2:0], w_query};
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_dx[k] = {r_pk[k].x[COORD_W-1], r_pk[k].x} - {r_pd.x[COORD_W-1], r_pd.x};
            n_dy[k] = {r_pk[k].y[COORD_W-1], r_pk[k].y} - {r_pd.y[COORD_W-1], r_pd.y};
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_lift[k]  = {r_sqx[k][SQ_W-1], r_sqx[k]} + {r_sqy[k][SQ_W-1], r_sqy[k]};
            n_minor[k] = {r_mp[k][SQ_W-1], r_mp[k]} - {r_mn[k][SQ_W-1], r_mn[k]};
            w_mlo[k]   = {1'b0, r_minor[k][MLO_W-1:0]};
            w_mhi[k]   = r_minor[k][LIFT_W-1:MLO_W];
            n_prod[k]  = (SUM_W'(r_phi[k]) <<< MLO_W) + SUM_W'(r_plo[k]);
        end
        n_det = r_prod[0] - r_prod[1] + r_prod[2];
        n_pos = !n_det[SUM_W-1] && (n_det != '0);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_dx[k]    <= n_dx[k];
            r_dy[k]    <= n_dy[k];
            r_sqx[k]   <= SQ_W'(r_dx[k]) * SQ_W'(r_dx[k]);
            r_sqy[k]   <= SQ_W'(r_dy[k]) * SQ_W'(r_dy[k]);
            r_lift[k]  <= n_lift[k];
            r_minor[k] <= n_minor[k];
            r_plo[k]   <= PLO_W'(r_lift[k]) * PLO_W'(w_mlo[k]);
            r_phi[k]   <= PHI_W'(r_lift[k]) * PHI_W'(w_mhi[k]);
            r_prod[k]  <= n_prod[k];
        end
        r_mp[0] <= SQ_W'(r_dx[1]) * SQ_W'(r_dy[2]);
        r_mn[0] <= SQ_W'(r_dx[2]) * SQ_W'(r_dy[1]);
        r_mp[1] <= SQ_W'(r_dx[0]) * SQ_W'(r_dy[2]);
        r_mn[1] <= SQ_W'(r_dx[2]) * SQ_W'(r_dy[0]);
        r_mp[2] <= SQ_W'(r_dx[0]) * SQ_W'(r_dy[1]);
        r_mn[2] <= SQ_W'(r_dx[1]) * SQ_W'(r_dy[0]);
        r_id2   <= r_pd.id;
        r_id3   <= r_id2;
        r_id4   <= r_id3;
        r_id5   <= r_id4;
        r_id6   <= r_id5;
        r_match <= n_pos ? {1'b0, r_id6} : NO_MATCH;
    end

    assign strobe     = r_vld[LATENCY-1];
    assign o_match_id = r_match;

    a_strobe_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        strobe |-> $past(start && !busy && (i_req_type == REQ_QUERY), LATENCY))
        else $error("result without a query transaction");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(start && !busy && (i_req_type == REQ_LOAD), LATENCY) |-> !strobe)
        else $error("load transaction produced a result");

    a_miss_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (strobe && o_match_id[RES_W-1]) |-> (o_match_id == NO_MATCH))
        else $error("negative result is not the no-match code");

    a_hit_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (strobe && !o_match_id[RES_W-1]) |->
        (o_match_id[ID_W-1:0] == $past(r_pd.id, LATENCY - 1)))
        else $error("matched id does not follow the test point");

endmodule

[sim/incircle_checker.sv]
`timescale 1ns / 1ps

module incircle_checker import iiq_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic                      i_req_type,
    input  logic        [IDX_W-1:0]   i_load_index,
    input  logic signed [COORD_W-1:0] i_point_x,
    input  logic signed [COORD_W-1:0] i_point_y,
    input  logic        [ID_W-1:0]    i_point_id,
    input  logic        [IDX_W-1:0]   i_query_d,
    input  logic        [IDX_W-1:0]   i_query_a,
    input  logic        [IDX_W-1:0]   i_query_b,
    input  logic        [IDX_W-1:0]   i_query_c,
    input  logic                      strobe,
    input  logic signed [RES_W-1:0]   o_match_id,
    output int                        n_errors,
    output int                        n_pending
);

    t_point           shadow_points [NUM_POINTS];
    logic [RES_W-1:0] expected_ids [$];

    function automatic logic [RES_W-1:0] incircle_match(t_point d, t_point a, t_point b,
                                                        t_point c);
        longint                    xa, ya, xb, yb, xc, yc;
        longint                    la, lb, lc, m1, m2, m3;
        logic signed [SUM_W-1:0]   wla, wlb, wlc, wm1, wm2, wm3, det;
        xa = longint'($signed(a.x)) - longint'($signed(d.x));
        ya = longint'($signed(a.y)) - longint'($signed(d.y));
        xb = longint'($signed(b.x)) - longint'($signed(d.x));
        yb = longint'($signed(b.y)) - longint'($signed(d.y));
        xc = longint'($signed(c.x)) - longint'($signed(d.x));
        yc = longint'($signed(c.y)) - longint'($signed(d.y));
        la = xa * xa + ya * ya;
        lb = xb * xb + yb * yb;
        lc = xc * xc + yc * yc;
        m1 = xb * yc - xc * yb;
        m2 = xa * yc - xc * ya;
        m3 = xa * yb - xb * ya;
        wla = SUM_W'(la);
        wlb = SUM_W'(lb);
        wlc = SUM_W'(lc);
        wm1 = SUM_W'(m1);
        wm2 = SUM_W'(m2);
        wm3 = SUM_W'(m3);
        det = wla * wm1 - wlb * wm2 + wlc * wm3;
        return (det > 0) ? {1'b0, d.id} : NO_MATCH;
    endfunction

    always @(posedge i_clk) begin : monitor
        logic [RES_W-1:0] want;
        t_point           pt;
        if (!i_rst_n) begin
            expected_ids.delete();
        end else begin
            if (strobe) begin
                if (expected_ids.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d",
                             $time, o_match_id);
                    n_errors++;
                end else begin
                    want = expected_ids.pop_front();
                    if (o_match_id !== want) begin
                        $display("%0t: match_id mismatch, expected %0d, actual %0d",
                                 $time, $signed(want), o_match_id);
                        n_errors++;
                    end
                end
            end
            if (start && !busy) begin
                if (i_req_type == REQ_LOAD) begin
                    pt.x  = i_point_x;
                    pt.y  = i_point_y;
                    pt.id = i_point_id;
                    shadow_points[i_load_index] = pt;
                end else begin
                    expected_ids.push_back(incircle_match(shadow_points[i_query_d],
                                                          shadow_points[i_query_a],
                                                          shadow_points[i_query_b],
                                                          shadow_points[i_query_c]));
                end
            end
        end
        n_pending = expected_ids.size();
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import iiq_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int QUIET_TAIL   = 200;
    localparam int STALL_LIMIT  = 1000;

    localparam logic signed [COORD_W-1:0] C_MIN = 16'h8000;
    localparam logic signed [COORD_W-1:0] C_MAX = 16'h7FFF;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic                      i_req_type;
    logic        [IDX_W-1:0]   i_load_index;
    logic signed [COORD_W-1:0] i_point_x;
    logic signed [COORD_W-1:0] i_point_y;
    logic        [ID_W-1:0]    i_point_id;
    logic        [IDX_W-1:0]   i_query_d;
    logic        [IDX_W-1:0]   i_query_a;
    logic        [IDX_W-1:0]   i_query_b;
    logic        [IDX_W-1:0]   i_query_c;
    logic                      strobe;
    logic signed [RES_W-1:0]   o_match_id;

    int n_errors;
    int n_pending;
    int stall_cycles = 0;

    bit             loaded [NUM_POINTS];
    int unsigned    loaded_list [$];

    indexed_incircle_query DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_load_index (i_load_index),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_point_id   (i_point_id),
        .i_query_d    (i_query_d),
        .i_query_a    (i_query_a),
        .i_query_b    (i_query_b),
        .i_query_c    (i_query_c),
        .strobe       (strobe),
        .o_match_id   (o_match_id)
    );

    incircle_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_load_index (i_load_index),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_point_id   (i_point_id),
        .i_query_d    (i_query_d),
        .i_query_a    (i_query_a),
        .i_query_b    (i_query_b),
        .i_query_c    (i_query_c),
        .strobe       (strobe),
        .o_match_id   (o_match_id),
        .n_errors     (n_errors),
        .n_pending    (n_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || strobe) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic drive_item(input logic rt, input logic [IDX_W-1:0] li,
                              input logic signed [COORD_W-1:0] px,
                              input logic signed [COORD_W-1:0] py,
                              input logic [ID_W-1:0] pid,
                              input logic [IDX_W-1:0] qd, input logic [IDX_W-1:0] qa,
                              input logic [IDX_W-1:0] qb, input logic [IDX_W-1:0] qc);
        @(negedge i_clk);
        start        <= 1'b1;
        i_req_type   <= rt;
        i_load_index <= li;
        i_point_x    <= px;
        i_point_y    <= py;
        i_point_id   <= pid;
        i_query_d    <= qd;
        i_query_a    <= qa;
        i_query_b    <= qb;
        i_query_c    <= qc;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_for(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start        <= 1'b0;
            i_req_type   <= 1'($urandom);
            i_load_index <= IDX_W'($urandom);
            i_point_x    <= COORD_W'($urandom);
            i_point_y    <= COORD_W'($urandom);
            i_point_id   <= ID_W'($urandom);
            i_query_d    <= IDX_W'($urandom);
            i_query_a    <= IDX_W'($urandom);
            i_query_b    <= IDX_W'($urandom);
            i_query_c    <= IDX_W'($urandom);
            @(posedge i_clk);
        end
    endtask

    task automatic load_point(input int unsigned idx, input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y,
                              input logic [ID_W-1:0] id);
        drive_item(REQ_LOAD, IDX_W'(idx), x, y, id, IDX_W'($urandom), IDX_W'($urandom),
                   IDX_W'($urandom), IDX_W'($urandom));
        if (!loaded[idx]) begin
            loaded[idx] = 1'b1;
            loaded_list.push_back(idx);
        end
    endtask

    task automatic run_query(input int unsigned d, input int unsigned a,
                             input int unsigned b, input int unsigned c);
        drive_item(REQ_QUERY, IDX_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                   ID_W'($urandom), IDX_W'(d), IDX_W'(a), IDX_W'(b), IDX_W'(c));
    endtask

    function automatic logic signed [COORD_W-1:0] random_coord(input int mode);
        case (mode)
            0: return COORD_W'($urandom);
            1, 2: return COORD_W'(int'($urandom_range(0, 128)) - 64);
            default: begin
                case ($urandom_range(0, 3))
                    0: return C_MIN;
                    1: return C_MAX;
                    2: return '0;
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    function automatic int unsigned pick_loaded();
        return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    endfunction

    initial begin : stimulus
        int          mode;
        int unsigned qd, qa, qb, qc;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_req_type   = REQ_LOAD;
        i_load_index = '0;
        i_point_x    = '0;
        i_point_y    = '0;
        i_point_id   = '0;
        i_query_d    = '0;
        i_query_a    = '0;
        i_query_b    = '0;
        i_query_c    = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        load_point(0, 16'sd0, 16'sd0, 16'h0000);
        load_point(1, C_MAX, C_MAX, 16'hFFFF);
        load_point(2, C_MIN, C_MIN, 16'h8001);
        load_point(3, C_MAX, C_MIN, 16'h1234);
        load_point(4, C_MIN, C_MAX, 16'hABCD);
        load_point(5, 16'sd10, 16'sd0, 16'h0005);
        load_point(6, 16'sd0, 16'sd10, 16'h0006);
        load_point(7, -16'sd10, 16'sd0, 16'h0007);
        load_point(8, 16'sd20, 16'sd0, 16'h0008);
        load_point(1023, 16'sd1, 16'sd1, 16'h7FFF);
        load_point(512, 16'sd0, -16'sd10, 16'h0200);
        run_query(0, 5, 6, 7);
        run_query(8, 5, 6, 7);
        run_query(0, 5, 7, 6);
        run_query(512, 5, 6, 7);
        run_query(5, 5, 6, 7);
        run_query(0, 5, 5, 6);
        run_query(0, 5, 7, 8);
        run_query(1, 2, 3, 4);
        run_query(2, 3, 1, 4);
        run_query(1023, 1, 4, 2);
        run_query(0, 2, 3, 1);

        @(negedge i_clk);
        start <= 1'b0;
        while (n_pending != 0) @(posedge i_clk);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 7) == 0)
                idle_for($urandom_range(1, 19));
            if (loaded_list.size() < 4 || $urandom_range(0, 3) == 0) begin
                mode = $urandom_range(0, 3);
                load_point($urandom_range(0, NUM_POINTS - 1), random_coord(mode),
                           random_coord(mode), ID_W'($urandom));
            end else begin
                qd = pick_loaded();
                qa = pick_loaded();
                qb = pick_loaded();
                qc = pick_loaded();
                case ($urandom_range(0, 11))
                    0: qa = qd;
                    1: qb = qa;
                    2: qc = qd;
                    default: ;
                endcase
                run_query(qd, qa, qb, qc);
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (n_pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[indexed_incircle_query.f]
rtl/iiq_pkg.sv
rtl/indexed_incircle_query.sv
sim/incircle_checker.sv
sim/testbench.sv
